// File: rtl/bracket_span_record_assembler_unit_defines.svh
`ifndef BRACKET_SPAN_RECORD_ASSEMBLER_UNIT_DEFINES_SVH
`define BRACKET_SPAN_RECORD_ASSEMBLER_UNIT_DEFINES_SVH

// Same-cycle implication checked on every clock once reset is released.
`define BSRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock once reset is released.
`define BSRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bsra_pkg.sv
package bsra_pkg;

    localparam int POSITION_W = 32;

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;

    localparam logic [2:0] TAG_READONLY = 3'd1;
    localparam logic [2:0] TAG_WRITABLE = 3'd2;
    localparam logic [2:0] TAG_POST     = 3'd3;
    localparam logic [2:0] TAG_PRE      = 3'd4;
    localparam logic [2:0] TAG_KEYS     = 3'd5;

    localparam logic [2:0] SLOT_READONLY = 3'd0;
    localparam logic [2:0] SLOT_WRITABLE = 3'd1;
    localparam logic [2:0] SLOT_POST     = 3'd2;
    localparam logic [2:0] SLOT_PRE      = 3'd3;
    localparam logic [2:0] SLOT_KEYS     = 3'd4;
    localparam logic [2:0] SLOT_NONE     = 3'd7;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int CMDQ_CNT_W = 3;

    typedef enum logic [2:0] {
        SEQ_READONLY,
        SEQ_WRITABLE,
        SEQ_POST,
        SEQ_PRE,
        SEQ_KEYS
    } seq_state_t;

    typedef enum logic {
        CMD_OPEN,
        CMD_CLOSE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [2:0] slot;
        logic       current;
        logic       ovf;
    } cmd_ctl_t;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic [1:0]            bracket_kind;
        logic [2:0]            key_tag;
    } in_item_t;

    typedef struct packed {
        logic [31:0] readonly_start;
        logic [31:0] readonly_end;
        logic [31:0] writable_start;
        logic [31:0] writable_end;
        logic [31:0] post_start;
        logic [31:0] post_end;
        logic [31:0] pre_start;
        logic [31:0] pre_end;
        logic [31:0] keys_start;
        logic [31:0] keys_end;
        logic [3:0]  closed_mask;
        logic        overflow_seen;
    } out_rec_t;

endpackage

// File: rtl/bsra_front.sv
module bsra_front #(
    parameter int STACK_DEPTH = 64,
    parameter int OFF_W       = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  bsra_pkg::in_item_t item,
    output logic               cmd_valid,
    output bsra_pkg::cmd_ctl_t cmd_ctl,
    output logic [OFF_W-1:0]   cmd_off,
    output logic [OFF_W-1:0]   cmd_pos
);
    import bsra_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = OFF_W + 4;

    seq_state_t       seq_reg;
    seq_state_t       seq_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             gen_reg;
    logic             gen_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [EW-1:0]    top_reg;
    logic [EW-1:0]    top_next;
    logic [EW-1:0]    below_reg;
    logic [EW-1:0]    stack_mem [STACK_DEPTH];
    logic             do_push;
    logic [OFF_W-1:0] pos_off;
    logic [2:0]       new_slot;
    logic [CW-1:0]    wr_count;
    logic [CW-1:0]    rd_count;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [OFF_W-1:0] top_off;
    logic [2:0]       top_slot;
    logic             top_gen;

    assign pos_off = OFF_W'(item.position);
    assign {top_off, top_slot, top_gen} = top_reg;

    assign wr_count = count_reg - CW'(1);
    assign rd_count = count_next - CW'(2);
    assign wr_addr  = wr_count[AW-1:0];
    assign rd_addr  = rd_count[AW-1:0];

    always_comb
    begin
        seq_next   = seq_reg;
        gen_next   = gen_reg;
        ovf_next   = ovf_reg;
        count_next = count_reg;
        top_next   = top_reg;
        do_push    = 1'b0;
        new_slot   = SLOT_NONE;
        cmd_valid  = 1'b0;
        cmd_ctl    = '{op: CMD_OPEN, slot: SLOT_NONE, current: 1'b0, ovf: ovf_reg};
        cmd_off    = top_off;
        cmd_pos    = pos_off;
        if (accept)
        begin
            case (item.bracket_kind)
                KIND_OPEN:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        do_push    = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (item.key_tag == TAG_READONLY)
                        begin
                            new_slot = SLOT_READONLY;
                            seq_next = SEQ_WRITABLE;
                        end
                        else if (item.key_tag == TAG_WRITABLE && seq_reg == SEQ_WRITABLE)
                        begin
                            new_slot = SLOT_WRITABLE;
                            seq_next = SEQ_POST;
                        end
                        else if (item.key_tag == TAG_POST && seq_reg == SEQ_POST)
                        begin
                            new_slot = SLOT_POST;
                            seq_next = SEQ_PRE;
                        end
                        else if (item.key_tag == TAG_PRE && seq_reg == SEQ_PRE)
                        begin
                            new_slot = SLOT_PRE;
                            seq_next = SEQ_KEYS;
                        end
                        else if (item.key_tag == TAG_KEYS && seq_reg == SEQ_KEYS)
                        begin
                            new_slot = SLOT_KEYS;
                            seq_next = SEQ_READONLY;
                            gen_next = ~gen_reg;
                        end
                        top_next     = {pos_off, new_slot, gen_reg};
                        cmd_valid    = (new_slot != SLOT_NONE);
                        cmd_ctl.op   = CMD_OPEN;
                        cmd_ctl.slot = new_slot;
                    end
                end
                KIND_CLOSE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next      = count_reg - CW'(1);
                        top_next        = below_reg;
                        cmd_valid       = (top_slot <= SLOT_KEYS);
                        cmd_ctl.op      = CMD_CLOSE;
                        cmd_ctl.slot    = top_slot;
                        cmd_ctl.current = (top_gen == gen_reg);
                        cmd_off         = top_off;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_READONLY;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            gen_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            gen_reg   <= gen_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    // Spill the old top on push; keep the entry under the top prefetched.
    always_ff @(posedge clk)
    begin
        if (do_push && count_reg != '0)
        begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (do_push)
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= stack_mem[rd_addr];
        end
    end

endmodule

// File: rtl/bsra_cmd_fifo.sv
module bsra_cmd_fifo #(
    parameter int OFF_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bsra_pkg::cmd_ctl_t in_ctl,
    input  logic [OFF_W-1:0]   in_off,
    input  logic [OFF_W-1:0]   in_pos,
    output logic               full,
    output logic               out_valid,
    output bsra_pkg::cmd_ctl_t out_ctl,
    output logic [OFF_W-1:0]   out_off,
    output logic [OFF_W-1:0]   out_pos,
    input  logic               out_pop
);
    import bsra_pkg::*;

    logic [CMDQ_CNT_W-1:0] count_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    cmd_ctl_t              ctl_mem [CMDQ_DEPTH];
    logic [OFF_W-1:0]      off_mem [CMDQ_DEPTH];
    logic [OFF_W-1:0]      pos_mem [CMDQ_DEPTH];
    logic                  do_wr;
    logic                  do_rd;

    assign full      = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_wr     = in_valid && !full;
    assign do_rd     = out_pop && out_valid;
    assign out_ctl   = ctl_mem[rd_ptr_reg];
    assign out_off   = off_mem[rd_ptr_reg];
    assign out_pos   = pos_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CMDQ_CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CMDQ_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ctl_mem[wr_ptr_reg] <= in_ctl;
            off_mem[wr_ptr_reg] <= in_off;
            pos_mem[wr_ptr_reg] <= in_pos;
        end
    end

endmodule

// File: rtl/bsra_back.sv
module bsra_back #(
    parameter int OFF_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  bsra_pkg::cmd_ctl_t q_ctl,
    input  logic [OFF_W-1:0]   q_off,
    input  logic [OFF_W-1:0]   q_pos,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output bsra_pkg::out_rec_t result
);
    import bsra_pkg::*;

    logic [OFF_W-1:0] work_starts_reg  [4];
    logic [OFF_W-1:0] work_starts_next [4];
    logic [OFF_W-1:0] work_ends_reg    [4];
    logic [OFF_W-1:0] work_ends_next   [4];
    logic [3:0]       work_closed_reg;
    logic [3:0]       work_closed_next;
    logic [OFF_W-1:0] pend_starts_reg  [4];
    logic [OFF_W-1:0] pend_starts_next [4];
    logic [OFF_W-1:0] pend_ends_reg    [4];
    logic [OFF_W-1:0] pend_ends_next   [4];
    logic [OFF_W-1:0] pend_keys_reg;
    logic [OFF_W-1:0] pend_keys_next;
    logic [3:0]       pend_closed_reg;
    logic [3:0]       pend_closed_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_rec_t         result_reg;
    out_rec_t         result_next;
    logic [1:0]       sidx;
    logic             is_keys;
    logic             stall;

    assign sidx    = q_ctl.slot[1:0];
    assign is_keys = (q_ctl.slot == SLOT_KEYS);
    assign stall   = q_valid && q_ctl.op == CMD_CLOSE && is_keys && out_valid_reg && !pop;
    assign q_pop   = q_valid && !stall;
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        work_starts_next = work_starts_reg;
        work_ends_next   = work_ends_reg;
        work_closed_next = work_closed_reg;
        pend_starts_next = pend_starts_reg;
        pend_ends_next   = pend_ends_reg;
        pend_keys_next   = pend_keys_reg;
        pend_closed_next = pend_closed_reg;
        out_valid_next   = out_valid_reg && !pop;
        result_next      = result_reg;
        if (q_pop)
        begin
            case (q_ctl.op)
                CMD_OPEN:
                begin
                    if (is_keys)
                    begin
                        pend_starts_next = work_starts_reg;
                        pend_ends_next   = work_ends_reg;
                        pend_closed_next = work_closed_reg;
                        pend_keys_next   = q_pos;
                        for (int i = 0; i < 4; i++)
                        begin
                            work_starts_next[i] = '0;
                            work_ends_next[i]   = '0;
                        end
                        work_closed_next = '0;
                    end
                    else
                    begin
                        if (q_ctl.slot == SLOT_READONLY)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                work_starts_next[i] = '0;
                                work_ends_next[i]   = '0;
                            end
                            work_closed_next = '0;
                        end
                        work_starts_next[sidx] = q_pos;
                    end
                end
                CMD_CLOSE:
                begin
                    if (is_keys)
                    begin
                        if (!q_ctl.current && pend_keys_reg == q_off)
                        begin
                            out_valid_next            = 1'b1;
                            result_next.readonly_start = 32'(pend_starts_reg[0]);
                            result_next.readonly_end   = 32'(pend_ends_reg[0]);
                            result_next.writable_start = 32'(pend_starts_reg[1]);
                            result_next.writable_end   = 32'(pend_ends_reg[1]);
                            result_next.post_start     = 32'(pend_starts_reg[2]);
                            result_next.post_end       = 32'(pend_ends_reg[2]);
                            result_next.pre_start      = 32'(pend_starts_reg[3]);
                            result_next.pre_end        = 32'(pend_ends_reg[3]);
                            result_next.keys_start     = 32'(pend_keys_reg);
                            result_next.keys_end       = 32'(q_pos);
                            result_next.closed_mask    = pend_closed_reg;
                            result_next.overflow_seen  = q_ctl.ovf;
                        end
                    end
                    else if (q_ctl.current)
                    begin
                        if (work_starts_reg[sidx] == q_off)
                        begin
                            work_ends_next[sidx]   = q_pos;
                            work_closed_next[sidx] = 1'b1;
                        end
                    end
                    else if (pend_starts_reg[sidx] == q_off)
                    begin
                        pend_ends_next[sidx]   = q_pos;
                        pend_closed_next[sidx] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                work_starts_reg[i] <= '0;
                work_ends_reg[i]   <= '0;
                pend_starts_reg[i] <= '0;
                pend_ends_reg[i]   <= '0;
            end
            work_closed_reg <= '0;
            pend_keys_reg   <= '0;
            pend_closed_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            work_starts_reg <= work_starts_next;
            work_ends_reg   <= work_ends_next;
            work_closed_reg <= work_closed_next;
            pend_starts_reg <= pend_starts_next;
            pend_ends_reg   <= pend_ends_next;
            pend_keys_reg   <= pend_keys_next;
            pend_closed_reg <= pend_closed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// File: rtl/bracket_span_record_assembler_unit.sv
// channel   direction  handshake          transaction
// item      in         push / full        one structural position (open, close, other)
// result    out        empty / pop        one finished record of five spans
//
// One item per cycle is taken while the command queue has room.
// A record's closing command enters the queue with its closing item; once the back
// end pops it from the queue, the command loads the record into the result register.
// The result register holds one record; while it waits, only an accountKeys
// close stalls the back end, and the front end stops once the 4-entry queue fills.
// Reset clears stack count, sequencer, records being assembled and flags; no clearing pass.
`include "bracket_span_record_assembler_unit_defines.svh"

module bracket_span_record_assembler_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bsra_pkg::in_item_t item,
    output logic               empty,
    input  logic               pop,
    output bsra_pkg::out_rec_t result
);
    import bsra_pkg::*;

    localparam int OFF_W = (OFFSET_BITS < POSITION_W) ? OFFSET_BITS : POSITION_W;

    logic             accept;
    logic             cmd_valid;
    cmd_ctl_t         cmd_ctl;
    logic [OFF_W-1:0] cmd_off;
    logic [OFF_W-1:0] cmd_pos;
    logic             q_valid;
    cmd_ctl_t         q_ctl;
    logic [OFF_W-1:0] q_off;
    logic [OFF_W-1:0] q_pos;
    logic             q_pop;

    assign accept = push && !full;

    bsra_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .OFF_W       (OFF_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ctl   (cmd_ctl),
        .cmd_off   (cmd_off),
        .cmd_pos   (cmd_pos)
    );

    bsra_cmd_fifo #(
        .OFF_W (OFF_W)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_ctl    (cmd_ctl),
        .in_off    (cmd_off),
        .in_pos    (cmd_pos),
        .full      (full),
        .out_valid (q_valid),
        .out_ctl   (q_ctl),
        .out_off   (q_off),
        .out_pos   (q_pos),
        .out_pop   (q_pop)
    );

    bsra_back #(
        .OFF_W (OFF_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ctl   (q_ctl),
        .q_off   (q_off),
        .q_pos   (q_pos),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    `BSRA_ASSERT_NOW(a_cmd_not_into_full, cmd_valid, !full, "command pushed into full queue")
    `BSRA_ASSERT_NEXT(a_cmd_lands_in_queue, cmd_valid, q_valid, "pushed command missing from queue")
    `BSRA_ASSERT_NOW(a_pop_only_valid, q_pop, q_valid, "queue popped while empty")
    `BSRA_ASSERT_NOW(a_result_from_keys_close, !empty && $past(empty), $past(q_pop && q_ctl.op == CMD_CLOSE && q_ctl.slot == SLOT_KEYS), "result without accountKeys close")

endmodule
